[sv/olfoc_pkg.sv]
// Shared constants, sine table and angle alignment helpers for the open-loop FOC PWM block.
package olfoc_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int SINE_TABLE_BITS = 8;
  localparam int TABLE_N         = 1 << SINE_TABLE_BITS;

  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam int          SQRT3_Q15   = 56756;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration register indexes
  localparam logic [1:0] REG_UQ_RATIO   = 2'd0;
  localparam logic [1:0] REG_ZERO_OFS   = 2'd1;
  localparam logic [1:0] REG_PAIR_CNT   = 2'd2;
  localparam logic [1:0] REG_PWM_PERIOD = 2'd3;

  typedef logic [14:0] sine_lut_t [0:TABLE_N];

  // Q30 Taylor series through x^15, truncating steps, rounded to Q15
  function automatic logic [14:0] sine_entry(input logic [63:0] j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (j * Q30_HALF_PI) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    r = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t t;
    for (int j = 0; j <= TABLE_N; j++) begin
      t[j] = sine_entry(64'(j));
    end
    return t;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  // 16-bit turn count to ANGLE_BITS, truncating when narrower
  function automatic logic [ANGLE_BITS-1:0] align_to_angle(input logic [15:0] v);
    logic [ANGLE_BITS+15:0] w;
    w = {v, {ANGLE_BITS{1'b0}}};
    return w[ANGLE_BITS+15 -: ANGLE_BITS];
  endfunction

  // ANGLE_BITS turn count back to 16 bits
  function automatic logic [15:0] align_to_16(input logic [ANGLE_BITS-1:0] v);
    logic [ANGLE_BITS+15:0] w;
    w = {v, 16'b0};
    return w[ANGLE_BITS+15 -: 16];
  endfunction

endpackage

[sv/open_loop_foc_pwm_top.sv]
// Open-loop FOC top level: angle accumulator, sequencer and three-phase PWM duty output.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | in_angle_step
//   out_    | output    | out_valid/out_stall | out_duty_a/b/c, out_shaft_position
//   cfg_    | input     | cfg_we            | cfg_index, cfg_data
//
// out_valid rises after the input transfer once seven products have passed one after another
// through the shared multiplier, plus angle, table, sum and load steps, so a tick transfers
// only after the previous one has been loaded into the output register.
// in_stall is high from transfer until the result is loaded into the output register.
// A result held by out_stall stalls only the final step; the next tick may transfer meanwhile.
// Synchronous reset clears the shaft angle and loads the configuration defaults.
module open_loop_foc_pwm_top
  import olfoc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_angle_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_duty_a,
  output logic [15:0]        out_duty_b,
  output logic [15:0]        out_duty_c,
  output logic [15:0]        out_shaft_position,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_M_ELEC, S_ELEC, S_LUT, S_M_SIN, S_M_COS, S_M_K, S_SUM,
    S_D_A, S_D_B, S_D_C, S_DONE
  } state_t;

  localparam logic signed [49:0] HALF = 50'sd1 <<< 45;
  localparam logic signed [49:0] ONE  = 50'sd1 <<< 46;

  state_t                  state_r, state_nxt;
  logic [ANGLE_BITS-1:0]   acc_r, acc_nxt;
  logic [14:0]             uq_r;
  logic [15:0]             ofs_r;
  logic [6:0]              pp_r;
  logic [15:0]             period_r;
  logic [ANGLE_BITS-1:0]   elec_r;
  logic signed [31:0]      al_r;
  logic [46:0]             va_r, vb_r, vc_r;
  logic [15:0]             da_r, db_r;
  logic                    out_valid_r;
  logic [15:0]             out_a_r, out_b_r, out_c_r, out_pos_r;

  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_r;
  logic                      lut_en;
  logic signed [15:0]        sin_r, cos_r;

  logic signed [49:0] a45, sb45, va, vb, vc;
  logic               in_xfer, out_free;

  function automatic logic [46:0] sat_phase(input logic signed [49:0] v);
    logic signed [49:0] r;
    r = v;
    if (v < 0) begin
      r = '0;
    end else if (v > ONE) begin
      r = ONE;
    end
    return r[46:0];
  endfunction

  olfoc_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  olfoc_sincos u_sincos (
    .clk   (clk),
    .en    (lut_en),
    .elec  (elec_r),
    .sin_r (sin_r),
    .cos_r (cos_r)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign lut_en    = (state_r == S_LUT);
  assign acc_nxt   = acc_r + align_to_angle(in_angle_step);

  // Inverse Park with Ud = 0, then inverse Clarke, all in Q46 of the supply
  always_comb begin
    a45  = -($signed({{18{al_r[31]}}, al_r}) <<< 15);
    sb45 = prod_r[49:0];
    va   = (a45 <<< 1) + HALF;
    vb   = sb45 - a45 + HALF;
    vc   = -a45 - sb45 + HALF;
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_M_ELEC: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-ANGLE_BITS){1'b0}}, acc_r});
        mul_b  = $signed({{(MUL_B_W-7){1'b0}}, pp_r});
      end
      S_M_SIN: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-15){1'b0}}, uq_r});
        mul_b  = MUL_B_W'(sin_r);
      end
      S_M_COS: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-15){1'b0}}, uq_r});
        mul_b  = MUL_B_W'(cos_r);
      end
      S_M_K: begin
        mul_en = 1'b1;
        mul_a  = prod_r[MUL_A_W-1:0];
        mul_b  = MUL_B_W'(SQRT3_Q15);
      end
      S_D_A: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, va_r});
        mul_b  = $signed({{(MUL_B_W-16){1'b0}}, period_r});
      end
      S_D_B: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, vb_r});
        mul_b  = $signed({{(MUL_B_W-16){1'b0}}, period_r});
      end
      S_D_C: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, vc_r});
        mul_b  = $signed({{(MUL_B_W-16){1'b0}}, period_r});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_M_ELEC;
      S_M_ELEC: state_nxt = S_ELEC;
      S_ELEC:   state_nxt = S_LUT;
      S_LUT:    state_nxt = S_M_SIN;
      S_M_SIN:  state_nxt = S_M_COS;
      S_M_COS:  state_nxt = S_M_K;
      S_M_K:    state_nxt = S_SUM;
      S_SUM:    state_nxt = S_D_A;
      S_D_A:    state_nxt = S_D_B;
      S_D_B:    state_nxt = S_D_C;
      S_D_C:    state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        acc_r <= acc_nxt;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uq_r     <= 15'd10923;
      ofs_r    <= 16'd0;
      pp_r     <= 7'd7;
      period_r <= 16'd4000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UQ_RATIO:   uq_r     <= cfg_data[14:0];
        REG_ZERO_OFS:   ofs_r    <= cfg_data;
        REG_PAIR_CNT:   pp_r     <= cfg_data[6:0];
        REG_PWM_PERIOD: period_r <= cfg_data;
        default:        uq_r     <= uq_r;
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == S_ELEC) begin
      elec_r <= prod_r[ANGLE_BITS-1:0] + align_to_angle(ofs_r);
    end
    if (state_r == S_M_COS) begin
      al_r <= prod_r[31:0];
    end
    if (state_r == S_SUM) begin
      va_r <= sat_phase(va);
      vb_r <= sat_phase(vb);
      vc_r <= sat_phase(vc);
    end
    if (state_r == S_D_B) begin
      da_r <= prod_r[61:46];
    end
    if (state_r == S_D_C) begin
      db_r <= prod_r[61:46];
    end
    if (state_r == S_DONE && out_free) begin
      out_a_r   <= da_r;
      out_b_r   <= db_r;
      out_c_r   <= prod_r[61:46];
      out_pos_r <= align_to_16(acc_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_duty_a         = out_a_r;
  assign out_duty_b         = out_b_r;
  assign out_duty_c         = out_c_r;
  assign out_shaft_position = out_pos_r;

endmodule

[sv/olfoc_mul.sv]
// Shared registered signed multiplier used for every product in the block.
module olfoc_mul
  import olfoc_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

[sv/olfoc_sincos.sv]
// Quarter-wave table lookup giving registered sine and cosine of the electrical angle.
module olfoc_sincos
  import olfoc_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] elec,
  output logic signed [15:0]    sin_r,
  output logic signed [15:0]    cos_r
);

  localparam logic [SINE_TABLE_BITS:0] TABLE_TOP = (SINE_TABLE_BITS+1)'(TABLE_N);

  logic [1:0]                 quad_s;
  logic [1:0]                 quad_c;
  logic [ANGLE_BITS-3:0]      rem;
  logic [ANGLE_BITS-3+SINE_TABLE_BITS:0] rem_w;
  logic [SINE_TABLE_BITS-1:0] j;

  function automatic logic signed [15:0] lookup(input logic [1:0] q,
                                                input logic [SINE_TABLE_BITS-1:0] jj);
    logic [SINE_TABLE_BITS:0] idx;
    logic [14:0]              mag;
    idx = q[0] ? (TABLE_TOP - {1'b0, jj}) : {1'b0, jj};
    mag = SINE_LUT[idx];
    return q[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  always_comb begin
    quad_s = elec[ANGLE_BITS-1:ANGLE_BITS-2];
    quad_c = quad_s + 2'd1;   // a quarter turn ahead
    rem    = elec[ANGLE_BITS-3:0];
    rem_w  = {rem, {SINE_TABLE_BITS{1'b0}}};
    j      = rem_w[ANGLE_BITS-3+SINE_TABLE_BITS -: SINE_TABLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= lookup(quad_s, j);
      cos_r <= lookup(quad_c, j);
    end
  end

endmodule
